// File: rtl/core/vefm_pkg.sv
`timescale 1ns / 1ps

package vefm_pkg;

    // Store geometry
    localparam int CAPACITY    = 1024;
    localparam int COORD_WIDTH = 16;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W       = 10;
    localparam int FIELD_W     = 16;
    localparam int CMP_W       = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;

    // One cell per face: +x, -x, +y, -y, +z, -z
    localparam int NUM_CELLS = 6;
    localparam int DRAIN_W   = $clog2(NUM_CELLS + 1);

    // Mode codes
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NO_INDEX = 2'd2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [COORD_WIDTH:0]   wcoord_t;

    localparam wcoord_t POS_ONE = wcoord_t'(1);

    // Stored block
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } blk_t;

    // Neighbor position one bit wider, so +-1 never wraps
    typedef struct packed {
        wcoord_t x;
        wcoord_t y;
        wcoord_t z;
    } pos_t;

    // Word passed down the cell chain
    typedef struct packed {
        logic vld;
        blk_t blk;
    } strm_t;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
        logic signed [FIELD_W-1:0] coord_z;
        logic [IDX_W-1:0]         block_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [FIELD_W-1:0] out_x;
        logic signed [FIELD_W-1:0] out_y;
        logic signed [FIELD_W-1:0] out_z;
        logic [NUM_CELLS-1:0]     exposed_mask;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TARGET,
        ST_SCAN,
        ST_DRAIN,
        ST_PUSH
    } state_t;

    // Input field to stored coordinate: sign-extend, keep low COORD_WIDTH bits
    function automatic coord_t to_coord(input logic signed [FIELD_W-1:0] v);
        logic signed [COORD_WIDTH+FIELD_W-1:0] wide;
        wide = {{COORD_WIDTH{v[FIELD_W-1]}}, v};
        return wide[COORD_WIDTH-1:0];
    endfunction

    // Stored coordinate to output field: sign-extend, keep low FIELD_W bits
    function automatic logic signed [FIELD_W-1:0] to_field(input coord_t c);
        logic signed [COORD_WIDTH+FIELD_W-1:0] wide;
        wide = {{FIELD_W{c[COORD_WIDTH-1]}}, c};
        return wide[FIELD_W-1:0];
    endfunction

    function automatic wcoord_t widen(input coord_t c);
        return {c[COORD_WIDTH-1], c};
    endfunction

endpackage

// File: rtl/core/vefm_ram.sv
`timescale 1ns / 1ps

module vefm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/core/vefm_cell.sv
`timescale 1ns / 1ps

module vefm_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  vefm_pkg::pos_t  want,
    input  vefm_pkg::strm_t in_strm,
    output vefm_pkg::strm_t out_strm,
    output logic           hit
);

    import vefm_pkg::*;

    pos_t  want_reg;
    logic  hit_reg;
    logic  hit_next;
    logic  vld_reg;
    blk_t  blk_reg;
    logic  match;

    // Passing block sits exactly at the wanted neighbor position
    assign match = in_strm.vld
                && (widen(in_strm.blk.x) == want_reg.x)
                && (widen(in_strm.blk.y) == want_reg.y)
                && (widen(in_strm.blk.z) == want_reg.z);

    always_comb begin
        hit_next = hit_reg;
        if (load) begin
            hit_next = 1'b0;
        end else if (match) begin
            hit_next = 1'b1;
        end
    end

    // Neighbor position is loaded once per query
    always_ff @(posedge aclk) begin
        if (load) begin
            want_reg <= want;
        end
        blk_reg <= in_strm.blk;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
            vld_reg <= 1'b0;
        end else begin
            hit_reg <= hit_next;
            vld_reg <= in_strm.vld;
        end
    end

    assign out_strm = '{vld: vld_reg, blk: blk_reg};
    assign hit      = hit_reg;

endmodule

// File: rtl/core/voxel_exposed_face_mask_top.sv
`timescale 1ns / 1ps
// Channel  Ports                     Word        Direction
// s_       s_valid s_ready s_word    in_word_t   in   append / query / clear
// m_       m_valid m_ready m_word    out_word_t  out  status, coords, face mask
//
// Append, clear, refused query and unused mode: accepted and answered without a scan.
// Good query: the store is read one entry per cycle through its single read port
// and streamed down a chain of six face cells.
// Reset (aresetn low, synchronous) empties the store; entries are not cleared.
// A finished word waits in the output register; a new word is accepted meanwhile,
// and the block holds a later result until m_ready frees the output register.

module voxel_exposed_face_mask_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vefm_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output vefm_pkg::out_word_t m_word
);

    import vefm_pkg::*;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [DRAIN_W-1:0] drain_cnt_reg, drain_cnt_next;
    blk_t               target_reg, target_next;
    out_word_t          res_reg, res_next;
    out_word_t          m_word_reg, m_word_next;
    logic               m_valid_reg, m_valid_next;
    logic               rd_vld_reg, rd_vld_next;

    logic               wr_en;
    blk_t               wr_blk;
    logic [ADDR_W-1:0]  rd_addr;
    blk_t               rd_blk;
    logic               cell_load;
    pos_t               want [NUM_CELLS];
    strm_t              chain [NUM_CELLS+1];
    logic [NUM_CELLS-1:0] hit_vec;
    out_word_t          res_now;
    logic               res_load;
    logic               out_free;
    logic               full;
    logic [CMP_W-1:0]   idx_ext;
    logic               q_ok;

    // Store
    assign wr_blk.x = to_coord(s_word.coord_x);
    assign wr_blk.y = to_coord(s_word.coord_y);
    assign wr_blk.z = to_coord(s_word.coord_z);

    vefm_ram #(
        .WIDTH ($bits(blk_t)),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (wr_blk),
        .rd_addr (rd_addr),
        .rd_data (rd_blk)
    );

    // Neighbor positions of the queried block, one per face
    always_comb begin
        want[0] = '{x: widen(rd_blk.x) + POS_ONE, y: widen(rd_blk.y), z: widen(rd_blk.z)};
        want[1] = '{x: widen(rd_blk.x) - POS_ONE, y: widen(rd_blk.y), z: widen(rd_blk.z)};
        want[2] = '{x: widen(rd_blk.x), y: widen(rd_blk.y) + POS_ONE, z: widen(rd_blk.z)};
        want[3] = '{x: widen(rd_blk.x), y: widen(rd_blk.y) - POS_ONE, z: widen(rd_blk.z)};
        want[4] = '{x: widen(rd_blk.x), y: widen(rd_blk.y), z: widen(rd_blk.z) + POS_ONE};
        want[5] = '{x: widen(rd_blk.x), y: widen(rd_blk.y), z: widen(rd_blk.z) - POS_ONE};
    end

    // Cell chain: each stored block walks past all six face cells
    assign chain[0].vld = rd_vld_reg;
    assign chain[0].blk = rd_blk;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        vefm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .load     (cell_load),
            .want     (want[k]),
            .in_strm  (chain[k]),
            .out_strm (chain[k+1]),
            .hit      (hit_vec[k])
        );
    end

    assign full     = (count_reg == COUNT_W'(CAPACITY));
    assign idx_ext  = CMP_W'(s_word.block_index);
    assign q_ok     = (idx_ext < CMP_W'(count_reg));
    assign out_free = !m_valid_reg || m_ready;

    // Sequencer: next state and datapath controls
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_ptr_next  = scan_ptr_reg;
        drain_cnt_next = drain_cnt_reg;
        target_next    = target_reg;
        res_next       = res_reg;
        m_word_next    = m_word_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        rd_vld_next    = 1'b0;
        wr_en          = 1'b0;
        rd_addr        = scan_ptr_reg[ADDR_W-1:0];
        s_ready        = 1'b0;
        cell_load      = 1'b0;
        res_now        = '0;
        res_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                rd_addr = idx_ext[ADDR_W-1:0];
                if (s_valid) begin
                    res_now.status = STAT_OK;
                    res_load       = 1'b1;
                    unique case (s_word.mode)
                        MODE_APPEND: begin
                            if (full) begin
                                res_now.status = STAT_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_QUERY: begin
                            if (q_ok) begin
                                res_load   = 1'b0;
                                state_next = ST_TARGET;
                            end else begin
                                res_now.status = STAT_NO_INDEX;
                            end
                        end
                        MODE_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TARGET: begin
                // Read data is the queried block
                target_next   = rd_blk;
                cell_load     = 1'b1;
                scan_ptr_next = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                rd_vld_next   = 1'b1;
                scan_ptr_next = scan_ptr_reg + 1'b1;
                if (scan_ptr_reg + 1'b1 == count_reg) begin
                    drain_cnt_next = '0;
                    state_next     = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                drain_cnt_next = drain_cnt_reg + 1'b1;
                if (drain_cnt_reg == DRAIN_W'(NUM_CELLS)) begin
                    res_now.status       = STAT_OK;
                    res_now.out_x        = to_field(target_reg.x);
                    res_now.out_y        = to_field(target_reg.y);
                    res_now.out_z        = to_field(target_reg.z);
                    res_now.exposed_mask = ~hit_vec;
                    res_load             = 1'b1;
                end
            end
            ST_PUSH: begin
                res_now  = res_reg;
                res_load = 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Result goes out now, or waits in the holding register
        if (res_load) begin
            if (out_free) begin
                m_word_next  = res_now;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end else begin
                res_next   = res_now;
                state_next = ST_PUSH;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        scan_ptr_reg  <= scan_ptr_next;
        drain_cnt_reg <= drain_cnt_next;
        target_reg    <= target_next;
        res_reg       <= res_next;
        m_word_reg    <= m_word_next;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            rd_vld_reg  <= rd_vld_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule
